// ===== sv/kis_pkg.sv =====
// ----------------------------------------------------------------------------
// kis_pkg
// Shared widths, codes and request structs for the key index shuffle block.
// ----------------------------------------------------------------------------
package kis_pkg;

  localparam int IDX_W       = 9;
  localparam int TABLE_DEPTH = 512;
  localparam int KW_W        = 10;
  localparam int BYTE_W      = 8;
  localparam int NIB_W       = 4;
  localparam int BCNT_W      = 2;
  localparam int LEN_W       = 4;

  localparam int KEY_SIZE_LARGE   = 512;
  localparam int KEY_SIZE_SMALL   = 256;
  localparam int ROUND_SIZE_LARGE = 98;
  localparam int ROUND_SIZE_SMALL = 60;

  localparam logic OP_INIT = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  localparam logic MODE_LARGE = 1'b0;
  localparam logic MODE_SMALL = 1'b1;

  // one read port, one write port
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
  } ram_req_t;

  // result issued alongside a table read
  typedef struct packed {
    logic             valid;
    logic [NIB_W-1:0] whitening;
    logic             last;
    logic             fwd;
    logic [IDX_W-1:0] fwd_data;
  } res_req_t;

endpackage

// ===== sv/kis_perm_ram.sv =====
// ----------------------------------------------------------------------------
// kis_perm_ram
// Permutation table: one registered read port, one write port.
// ----------------------------------------------------------------------------
module kis_perm_ram (
  input  logic                       clk,
  input  kis_pkg::ram_req_t          req,
  output logic [kis_pkg::IDX_W-1:0]  rd_data
);

  logic [kis_pkg::IDX_W-1:0] mem [kis_pkg::TABLE_DEPTH];
  logic [kis_pkg::IDX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/kis_ctrl.sv =====
// ----------------------------------------------------------------------------
// kis_ctrl
// Shuffle/whitening sequencer: slot position, phase, byte count, candidate
// computation, swap write scheduling, read forwarding and the clear sweep.
// ----------------------------------------------------------------------------
module kis_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        mode,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [kis_pkg::BYTE_W-1:0]  in_random_byte,
  input  logic                        s1_free,
  input  logic [kis_pkg::IDX_W-1:0]   ram_q,
  output kis_pkg::ram_req_t           ram_req,
  output kis_pkg::res_req_t           res_req
);

  localparam logic [kis_pkg::KW_W-1:0] KW_L = kis_pkg::KW_W'(kis_pkg::KEY_SIZE_LARGE);
  localparam logic [kis_pkg::KW_W-1:0] KW_S = kis_pkg::KW_W'(kis_pkg::KEY_SIZE_SMALL);
  localparam logic [kis_pkg::KW_W-1:0] RW_L = kis_pkg::KW_W'(kis_pkg::ROUND_SIZE_LARGE);
  localparam logic [kis_pkg::KW_W-1:0] RW_S = kis_pkg::KW_W'(kis_pkg::ROUND_SIZE_SMALL);
  localparam logic [kis_pkg::IDX_W-1:0] LAST_ADDR =
    kis_pkg::IDX_W'(kis_pkg::TABLE_DEPTH - 1);

  logic [kis_pkg::IDX_W-1:0]  pos_r, pos_nxt;
  logic                       phase_r, phase_nxt;
  logic [kis_pkg::BCNT_W-1:0] bc_r, bc_nxt;
  logic                       acc23_r, acc23_nxt;
  logic                       sweep_r, sweep_nxt;
  logic [kis_pkg::IDX_W-1:0]  sweep_cnt_r, sweep_cnt_nxt;
  logic                       sw1_r, sw1_nxt;
  logic                       sw2_r, sw2_nxt;
  logic [kis_pkg::IDX_W-1:0]  swp_pos_r, swp_pos_nxt;
  logic [kis_pkg::IDX_W-1:0]  swp_cand_r, swp_cand_nxt;
  logic [kis_pkg::IDX_W-1:0]  posval_r, posval_nxt;

  logic                       accept, is_init, is_shuf, is_white, word_done;
  logic [kis_pkg::KW_W-1:0]   kw, rw, pos_ext, d, cand, wnext;
  logic [kis_pkg::IDX_W-1:0]  d9, top9, top, p1;
  logic [kis_pkg::LEN_W-1:0]  n;
  logic                       in_range, cand_ok, advance, do_swap, end_round, is_last;
  logic [kis_pkg::IDX_W-1:0]  rd_addr;

  assign kw = (mode == kis_pkg::MODE_SMALL) ? KW_S : KW_L;
  assign rw = (mode == kis_pkg::MODE_SMALL) ? RW_S : RW_L;

  assign in_ready  = !sweep_r && s1_free;
  assign accept    = in_valid && in_ready;
  assign is_init   = accept && (in_op == kis_pkg::OP_INIT);
  assign is_shuf   = accept && (in_op == kis_pkg::OP_BYTE) && !phase_r;
  assign is_white  = accept && (in_op == kis_pkg::OP_BYTE) && phase_r;
  assign word_done = is_shuf && (bc_r == kis_pkg::BCNT_W'(3));

  // candidate: top n bits of the word, n = bit length of kw-1-pos
  assign pos_ext  = {1'b0, pos_r};
  assign in_range = pos_ext < kw;
  assign d        = kw - kis_pkg::KW_W'(1) - pos_ext;
  assign d9       = d[kis_pkg::IDX_W-1:0];

  always_comb begin
    n = '0;
    for (int i = 0; i < kis_pkg::IDX_W; i++) begin
      if (d9[i]) begin
        n = kis_pkg::LEN_W'(i + 1);
      end
    end
  end

  // word bits [31:23]: incoming byte is the top byte, bit 23 came with byte 2
  assign top9      = {in_random_byte, acc23_r};
  assign top       = top9 >> (kis_pkg::LEN_W'(kis_pkg::IDX_W) - n);
  assign cand      = pos_ext + {1'b0, top};
  assign cand_ok   = cand < kw;
  assign advance   = !in_range || cand_ok;
  assign do_swap   = in_range && cand_ok;
  assign p1        = pos_r + kis_pkg::IDX_W'(1);
  assign end_round = ({1'b0, p1} >= rw) || (p1 == '0);

  assign wnext   = pos_ext + kis_pkg::KW_W'(1);
  assign is_last = (wnext >= rw) || wnext[kis_pkg::KW_W-1];

  assign rd_addr = word_done ? cand[kis_pkg::IDX_W-1:0] : pos_r;

  always_comb begin
    ram_req.rd_en   = is_white || (is_shuf && bc_r[1]);
    ram_req.rd_addr = rd_addr;
    ram_req.wr_en   = sweep_r || sw1_r || sw2_r;
    if (sweep_r) begin
      ram_req.wr_addr = sweep_cnt_r;
      ram_req.wr_data = sweep_cnt_r;
    end else if (sw1_r) begin
      ram_req.wr_addr = swp_pos_r;
      ram_req.wr_data = ram_q;
    end else begin
      ram_req.wr_addr = swp_cand_r;
      ram_req.wr_data = posval_r;
    end
  end

  // a read right after a swap sees the writes still in flight
  always_comb begin
    res_req.valid     = is_white;
    res_req.whitening = in_random_byte[kis_pkg::NIB_W-1:0];
    res_req.last      = is_last;
    res_req.fwd       = 1'b0;
    res_req.fwd_data  = ram_q;
    if ((sw1_r || sw2_r) && (rd_addr == swp_cand_r)) begin
      res_req.fwd      = 1'b1;
      res_req.fwd_data = posval_r;
    end else if (sw1_r && (rd_addr == swp_pos_r)) begin
      res_req.fwd      = 1'b1;
      res_req.fwd_data = ram_q;
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    bc_nxt        = bc_r;
    acc23_nxt     = acc23_r;
    sweep_nxt     = sweep_r;
    sweep_cnt_nxt = sweep_cnt_r;
    sw1_nxt       = 1'b0;
    sw2_nxt       = sw1_r;
    swp_pos_nxt   = swp_pos_r;
    swp_cand_nxt  = swp_cand_r;
    posval_nxt    = posval_r;

    if (sweep_r) begin
      sweep_cnt_nxt = sweep_cnt_r + kis_pkg::IDX_W'(1);
      if (sweep_cnt_r == LAST_ADDR) begin
        sweep_nxt = 1'b0;
      end
    end

    if (is_init) begin
      pos_nxt       = '0;
      phase_nxt     = 1'b0;
      bc_nxt        = '0;
      sweep_nxt     = 1'b1;
      sweep_cnt_nxt = '0;
      sw2_nxt       = 1'b0;
    end

    if (is_shuf) begin
      bc_nxt = bc_r + kis_pkg::BCNT_W'(1);
      if (bc_r == kis_pkg::BCNT_W'(2)) begin
        acc23_nxt = in_random_byte[kis_pkg::BYTE_W-1];
      end
    end

    if (word_done) begin
      // ram_q still holds table[pos] from the byte 2 read
      posval_nxt   = ram_q;
      swp_pos_nxt  = pos_r;
      swp_cand_nxt = cand[kis_pkg::IDX_W-1:0];
      sw1_nxt      = do_swap;
      if (advance) begin
        if (end_round) begin
          pos_nxt   = '0;
          phase_nxt = 1'b1;
        end else begin
          pos_nxt = p1;
        end
      end
    end

    if (is_white) begin
      if (is_last) begin
        pos_nxt   = '0;
        phase_nxt = 1'b0;
      end else begin
        pos_nxt = wnext[kis_pkg::IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      phase_r     <= 1'b0;
      bc_r        <= '0;
      acc23_r     <= 1'b0;
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
      sw1_r       <= 1'b0;
      sw2_r       <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      bc_r        <= bc_nxt;
      acc23_r     <= acc23_nxt;
      sweep_r     <= sweep_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      sw1_r       <= sw1_nxt;
      sw2_r       <= sw2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    swp_pos_r  <= swp_pos_nxt;
    swp_cand_r <= swp_cand_nxt;
    posval_r   <= posval_nxt;
  end

endmodule

// ===== sv/kis_out.sv =====
// ----------------------------------------------------------------------------
// kis_out
// Read-data stage followed by the result register.
// ----------------------------------------------------------------------------
module kis_out (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kis_pkg::res_req_t          res_req,
  input  logic [kis_pkg::IDX_W-1:0]  ram_q,
  output logic                       s1_free,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kis_pkg::IDX_W-1:0]  out_key_index,
  output logic [kis_pkg::NIB_W-1:0]  out_whitening,
  output logic                       out_last
);

  logic                      s1_valid_r, s1_valid_nxt;
  logic [kis_pkg::NIB_W-1:0] s1_white_r;
  logic                      s1_last_r;
  logic                      s1_fwd_r;
  logic [kis_pkg::IDX_W-1:0] s1_fwd_data_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [kis_pkg::IDX_W-1:0] out_key_r;
  logic [kis_pkg::NIB_W-1:0] out_white_r;
  logic                      out_last_r;
  logic                      out_free, s1_move;
  logic [kis_pkg::IDX_W-1:0] s1_key;

  assign out_free = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_free;
  assign s1_free  = !s1_valid_r || out_free;
  assign s1_key   = s1_fwd_r ? s1_fwd_data_r : ram_q;

  always_comb begin
    s1_valid_nxt = s1_valid_r && !out_free;
    if (res_req.valid) begin
      s1_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r && !out_ready;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_req.valid) begin
      s1_white_r    <= res_req.whitening;
      s1_last_r     <= res_req.last;
      s1_fwd_r      <= res_req.fwd;
      s1_fwd_data_r <= res_req.fwd_data;
    end
    if (s1_move) begin
      out_key_r   <= s1_key;
      out_white_r <= s1_white_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_index = out_key_r;
  assign out_whitening = out_white_r;
  assign out_last      = out_last_r;

endmodule

// ===== sv/key_index_shuffle_whitening.sv =====
// ----------------------------------------------------------------------------
// key_index_shuffle_whitening
// Partial Fisher-Yates shuffle of a 512-entry key index table driven by
// random bytes, with rejection sampling, followed by whitening results.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   cfg     | cfg_valid cfg_ready cfg_mode            | in
//   in      | in_valid in_ready in_op in_random_byte  | in
//   out     | out_valid out_ready out_key_index       | out
//           | out_whitening out_last                  |
//
// One item per cycle while in_ready is high. A result passes the table read and
// the read-data stage into the result register; swaps use the single table
// write port after a word completes, writing pos and then the candidate slot,
// with forwarding to cover reads meanwhile. After reset and after every init
// item the table is rewritten to identity, one entry a cycle, with in_ready
// low (cfg is taken throughout). With out_ready low, two results are held, then in_ready drops.
// ----------------------------------------------------------------------------
module key_index_shuffle_whitening (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_mode,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [kis_pkg::BYTE_W-1:0]  in_random_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kis_pkg::IDX_W-1:0]   out_key_index,
  output logic [kis_pkg::NIB_W-1:0]   out_whitening,
  output logic                        out_last
);

  logic                      mode_r, mode_nxt;
  logic                      s1_free;
  logic [kis_pkg::IDX_W-1:0] ram_q;
  kis_pkg::ram_req_t         ram_req;
  kis_pkg::res_req_t         res_req;

  assign cfg_ready = 1'b1;
  assign mode_nxt  = (cfg_valid && cfg_ready) ? cfg_mode : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= kis_pkg::MODE_LARGE;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  kis_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .mode           (mode_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_random_byte (in_random_byte),
    .s1_free        (s1_free),
    .ram_q          (ram_q),
    .ram_req        (ram_req),
    .res_req        (res_req)
  );

  kis_perm_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_q)
  );

  kis_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_req       (res_req),
    .ram_q         (ram_q),
    .s1_free       (s1_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key_index (out_key_index),
    .out_whitening (out_whitening),
    .out_last      (out_last)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for key_index_shuffle_whitening.
// Streams random bytes through the shuffle and whitening phases, keeps its own
// copy of the key index permutation and checks every result in order. Mode is
// switched only while nothing is in flight, at phase boundaries and mid-round.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [kis_pkg::IDX_W-1:0] key_index;
  logic [kis_pkg::NIB_W-1:0] whitening;
  logic                      last;
} key_result_t;

class perm_shuffle_tracker;
  logic [kis_pkg::IDX_W-1:0]  perm [kis_pkg::TABLE_DEPTH];
  logic [kis_pkg::IDX_W-1:0]  slot;
  logic [kis_pkg::BCNT_W-1:0] byte_cnt;
  logic [31:0]                word_acc;
  logic                       whiten;
  logic                       mode;
  key_result_t                pending_results [$];
  int unsigned                items, inits, swaps, rejects, results, mismatches;

  function new();
    mode = kis_pkg::MODE_LARGE;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < kis_pkg::TABLE_DEPTH; i++) perm[i] = kis_pkg::IDX_W'(i);
    slot     = '0;
    byte_cnt = '0;
    word_acc = '0;
    whiten   = 1'b0;
  endfunction

  function int unsigned key_size();
    return (mode == kis_pkg::MODE_SMALL) ? kis_pkg::KEY_SIZE_SMALL
                                         : kis_pkg::KEY_SIZE_LARGE;
  endfunction

  function int unsigned round_width();
    return (mode == kis_pkg::MODE_SMALL) ? kis_pkg::ROUND_SIZE_SMALL
                                         : kis_pkg::ROUND_SIZE_LARGE;
  endfunction

  // one rejection-sampled Fisher-Yates step on a completed word
  function void shuffle_word(logic [31:0] w);
    int unsigned kw, rw, d, n, top, cand, nxt;
    logic [kis_pkg::IDX_W-1:0] tmp;
    logic advance;
    kw = key_size();
    rw = round_width();
    advance = 1'b1;
    if (slot < kw) begin
      d = kw - 1 - slot;
      n = 0;
      while (d != 0) begin
        n++;
        d = d >> 1;
      end
      top  = (n == 0) ? 0 : (w >> (32 - n));
      cand = slot + top;
      if (cand < kw) begin
        tmp             = perm[slot];
        perm[slot]      = perm[cand[8:0]];
        perm[cand[8:0]] = tmp;
        swaps++;
      end else begin
        advance = 1'b0;
        rejects++;
      end
    end
    if (advance) begin
      nxt = (slot + 1) % kis_pkg::TABLE_DEPTH;
      if (nxt >= rw || nxt == 0) begin
        nxt    = 0;
        whiten = 1'b1;
      end
      slot = kis_pkg::IDX_W'(nxt);
    end
  endfunction

  function void apply_item(logic op, logic [kis_pkg::BYTE_W-1:0] rbyte);
    int unsigned nxt;
    key_result_t r;
    items++;
    if (op == kis_pkg::OP_INIT) begin
      inits++;
      restart();
    end else if (!whiten) begin
      word_acc = word_acc | ({24'd0, rbyte} << (8 * byte_cnt));
      byte_cnt = byte_cnt + 1'b1;
      if (byte_cnt == 0) begin
        shuffle_word(word_acc);
        word_acc = '0;
      end
    end else begin
      nxt         = slot + 1;
      r.key_index = perm[slot];
      r.whitening = rbyte[3:0];
      r.last      = (nxt >= round_width()) || (nxt >= kis_pkg::TABLE_DEPTH);
      pending_results.push_back(r);
      if (r.last) begin
        slot   = '0;
        whiten = 1'b0;
      end else begin
        slot = kis_pkg::IDX_W'(nxt);
      end
    end
  endfunction

  function void check_result(key_result_t got);
    key_result_t exp;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result key_index %0d whitening %0d last %0d",
               $time, got.key_index, got.whitening, got.last);
      mismatches++;
      return;
    end
    exp = pending_results.pop_front();
    results++;
    if (got.key_index !== exp.key_index) begin
      $display("%0t: key_index expected %0d actual %0d", $time, exp.key_index, got.key_index);
      mismatches++;
    end
    if (got.whitening !== exp.whitening) begin
      $display("%0t: whitening expected %0d actual %0d", $time, exp.whitening, got.whitening);
      mismatches++;
    end
    if (got.last !== exp.last) begin
      $display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
      mismatches++;
    end
  endfunction
endclass

module tb;

  localparam int SETTLE_CYCLES   = 10;
  localparam int QUIET_LIMIT     = 3000;
  localparam int NUM_CHUNKS      = 8;
  localparam int ITEMS_PER_CHUNK = 179;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       cfg_valid      = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_mode       = kis_pkg::MODE_LARGE;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic                       in_op          = kis_pkg::OP_BYTE;
  logic [kis_pkg::BYTE_W-1:0] in_random_byte = '0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic [kis_pkg::IDX_W-1:0]  out_key_index;
  logic [kis_pkg::NIB_W-1:0]  out_whitening;
  logic                       out_last;

  perm_shuffle_tracker tracker;
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         quiet_cycles   = 0;
  int unsigned         mode_writes    = 0;

  key_index_shuffle_whitening uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_mode       (cfg_mode),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_random_byte (in_random_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_key_index  (out_key_index),
    .out_whitening  (out_whitening),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result('{out_key_index, out_whitening, out_last});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic op, input logic [kis_pkg::BYTE_W-1:0] rbyte);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_random_byte <= rbyte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.apply_item(op, rbyte);
  endtask

  // hold off the sender until every expected result is out, then let
  // any trailing swap finish
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_mode  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    tracker.mode  = m;
    mode_writes++;
  endtask

  initial begin
    int unsigned whiten_flips;
    int unsigned shuffle_flips;
    int unsigned r;
    logic [kis_pkg::BYTE_W-1:0] rbyte;

    tracker       = new();
    whiten_flips  = 2;
    shuffle_flips = 2;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: init with a nonzero byte, widest draw, zero draw, a rejected
    // word, then a mode switch mid-round
    send_item(kis_pkg::OP_INIT, 8'hA5);
    repeat (4) send_item(kis_pkg::OP_BYTE, 8'hFF);
    repeat (4) send_item(kis_pkg::OP_BYTE, 8'h00);
    send_item(kis_pkg::OP_BYTE, 8'h00);
    send_item(kis_pkg::OP_BYTE, 8'h00);
    send_item(kis_pkg::OP_BYTE, 8'h00);
    send_item(kis_pkg::OP_BYTE, 8'hFF);
    write_mode(kis_pkg::MODE_SMALL);
    send_item(kis_pkg::OP_BYTE, 8'h12);
    send_item(kis_pkg::OP_BYTE, 8'h34);
    send_item(kis_pkg::OP_BYTE, 8'h56);
    send_item(kis_pkg::OP_BYTE, 8'h80);
    send_item(kis_pkg::OP_INIT, 8'h5A);
    write_mode(kis_pkg::MODE_LARGE);

    for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
      case (chunk % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct = 12;
        end
      endcase
      write_mode(1'($urandom_range(0, 1)));
      for (int i = 0; i < ITEMS_PER_CHUNK; i++) begin
        // shrink the round while the slot is already past the small round size
        if (tracker.mode == kis_pkg::MODE_LARGE &&
            tracker.slot >= kis_pkg::ROUND_SIZE_SMALL &&
            $urandom_range(0, 39) == 0) begin
          if (tracker.whiten && whiten_flips != 0) begin
            whiten_flips--;
            write_mode(kis_pkg::MODE_SMALL);
          end else if (!tracker.whiten && shuffle_flips != 0) begin
            shuffle_flips--;
            write_mode(kis_pkg::MODE_SMALL);
          end
        end
        r = $urandom_range(0, 19);
        if (r < 3)
          rbyte = 8'hFF;
        else if (r < 5)
          rbyte = 8'h00;
        else
          rbyte = kis_pkg::BYTE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 249) == 0)
          send_item(kis_pkg::OP_INIT, rbyte);
        else
          send_item(kis_pkg::OP_BYTE, rbyte);
      end
    end

    send_idle_pct = 0;
    drain();
    $display("Sent %0d items (%0d inits) over %0d mode writes; %0d swaps, %0d rejected words.",
             tracker.items, tracker.inits, mode_writes, tracker.swaps, tracker.rejects);
    $display("Checked %0d whitening results, %0d mismatches.",
             tracker.results, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
